// ===== sv/rpd_pkg.sv =====
package rpd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned IDX_W  = 17;

    // start-of-packet codes
    localparam logic [BYTE_W-1:0] SOP_FIRST = 8'hFF;
    localparam logic [BYTE_W-1:0] SOP_SYNC  = 8'hFF;
    localparam logic [BYTE_W-1:0] SOP_ASYNC = 8'hFE;

    // header size and position of the last length byte
    localparam logic [IDX_W-1:0] HEADER_BYTES = 17'd5;
    localparam logic [IDX_W-1:0] LEN_BYTE_POS = 17'd4;
    localparam logic [IDX_W-1:0] FIRST_BODY   = 17'd2;

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_FIRST = 2'd1,
        PH_BODY  = 2'd2,
        PH_FLUSH = 2'd3
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] packet_byte;
        logic [IDX_W-1:0]  byte_index;
        logic              is_async;
        logic              last_of_packet;
    } t_result;

endpackage

// ===== sv/rpd_if.sv =====
interface rpd_byte_if import rpd_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rpd_pkt_if import rpd_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] packet_byte;
    logic [IDX_W-1:0]  byte_index;
    logic              is_async;
    logic              last_of_packet;

    modport source (output valid, output packet_byte, output byte_index,
                    output is_async, output last_of_packet, input ready);
    modport sink   (input valid, input packet_byte, input byte_index,
                    input is_async, input last_of_packet, output ready);
endinterface

// ===== sv/response_packet_deframer_core.sv =====
// Channel   Dir  Port    Payload
// rx bytes  in   i_rx    rx_byte[7:0]
// packets   out  o_pkt   packet_byte[7:0], byte_index[16:0], is_async, last_of_packet
//
// One byte per cycle sustained while the output is not stalled; a result reaches the
// output register through the input register, then framer logic into the output
// register. A packet byte is sent when the following stream byte is processed.
// i_rst_n is synchronous, active low; it empties both registers and restarts the hunt.
// A stalled output holds its transaction; the input keeps flowing while the
// output register is free or being drained, so a byte with no result never waits.
module response_packet_deframer_core import rpd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rpd_byte_if.sink  i_rx,
    rpd_pkt_if.source o_pkt
);

    logic              in_valid;
    logic [BYTE_W-1:0] in_byte;
    logic              res_valid;
    t_result           res;
    logic              out_free;
    logic              adv;
    logic              load;

    // the held byte advances unless its result has nowhere to go
    assign adv  = in_valid && (!res_valid || out_free);
    assign load = adv && res_valid;

    rpd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_adv   (adv),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    rpd_framer u_framer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_byte      (in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    rpd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_res   (res),
        .o_free  (out_free),
        .o_pkt   (o_pkt)
    );

endmodule

// ===== sv/rpd_in_reg.sv =====
module rpd_in_reg import rpd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rpd_byte_if.sink          i_rx,
    input  logic              i_adv,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_byte
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;

    // slot is free when empty or being drained this cycle
    assign i_rx.ready = !r_valid || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_rx.valid && i_rx.ready) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// ===== sv/rpd_framer.sv =====
module rpd_framer import rpd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic [BYTE_W-1:0] i_byte,
    output logic              o_res_valid,
    output t_result           o_res
);

    t_phase            r_phase, n_phase;
    logic              r_kind, n_kind;
    logic [IDX_W-1:0]  r_count, n_count;
    logic [BYTE_W-1:0] r_len_hi, n_len_hi;
    logic [IDX_W-1:0]  r_total, n_total;

    logic              w_sop;
    logic [15:0]       w_len;
    logic [IDX_W-1:0]  w_total_new;
    logic [IDX_W-1:0]  w_total_sel;
    logic [IDX_W-1:0]  w_count_inc;

    assign w_sop       = (i_byte == SOP_SYNC) || (i_byte == SOP_ASYNC);
    assign w_len       = r_kind ? {r_len_hi, i_byte} : {8'h00, i_byte};
    assign w_total_new = HEADER_BYTES + {1'b0, w_len};
    assign w_total_sel = (r_count == LEN_BYTE_POS) ? w_total_new : r_total;
    assign w_count_inc = r_count + 17'd1;

    // next state
    always_comb begin
        n_phase  = r_phase;
        n_kind   = r_kind;
        n_count  = r_count;
        n_len_hi = r_len_hi;
        n_total  = r_total;
        unique case (r_phase)
            PH_HUNT, PH_FLUSH: begin
                n_phase = (i_byte == SOP_FIRST) ? PH_FIRST : PH_HUNT;
            end
            PH_FIRST: begin
                if (w_sop) begin
                    n_kind   = (i_byte == SOP_ASYNC);
                    n_len_hi = i_byte;
                    n_count  = FIRST_BODY;
                    n_total  = '0;
                    n_phase  = PH_BODY;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            PH_BODY: begin
                n_total  = w_total_sel;
                n_len_hi = i_byte;
                n_count  = w_count_inc;
                if (r_count >= LEN_BYTE_POS && w_count_inc >= w_total_sel) begin
                    n_phase = PH_FLUSH;
                end
            end
        endcase
    end

    // result: each packet byte leaves one input later
    always_comb begin
        o_res_valid          = 1'b0;
        o_res.packet_byte    = r_len_hi;
        o_res.byte_index     = r_count - 17'd1;
        o_res.is_async       = r_kind;
        o_res.last_of_packet = 1'b0;
        unique case (r_phase)
            PH_HUNT: begin
                o_res_valid = 1'b0;
            end
            PH_FLUSH: begin
                o_res_valid          = 1'b1;
                o_res.byte_index     = r_total - 17'd1;
                o_res.last_of_packet = 1'b1;
            end
            PH_FIRST: begin
                o_res_valid       = w_sop;
                o_res.packet_byte = SOP_FIRST;
                o_res.byte_index  = '0;
                o_res.is_async    = (i_byte == SOP_ASYNC);
            end
            PH_BODY: begin
                o_res_valid = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_kind   <= 1'b0;
            r_count  <= '0;
            r_len_hi <= '0;
            r_total  <= '0;
        end else if (i_adv) begin
            r_phase  <= n_phase;
            r_kind   <= n_kind;
            r_count  <= n_count;
            r_len_hi <= n_len_hi;
            r_total  <= n_total;
        end
    end

    // nothing is sent while hunting
    a_hunt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HUNT) |-> !o_res_valid)
        else $error("result produced while hunting");

    // last mark only from the flush phase
    a_last_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.last_of_packet) |-> (r_phase == PH_FLUSH))
        else $error("last mark outside flush");

    // flush always returns to hunting, or straight to the start pair on a 0xFF
    a_flush_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && r_phase == PH_FLUSH) |=> (r_phase == PH_HUNT || r_phase == PH_FIRST))
        else $error("flush did not return to hunt");

    // inside a packet the start pair is always counted
    a_body_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY) |-> (r_count >= FIRST_BODY))
        else $error("body count below start pair");

endmodule

// ===== sv/rpd_out_reg.sv =====
module rpd_out_reg import rpd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    output logic    o_free,
    rpd_pkt_if.source o_pkt
);

    logic    r_valid;
    t_result r_res;

    // free when empty or the held transaction leaves now
    assign o_free = !r_valid || o_pkt.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_pkt.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_pkt.valid          = r_valid;
    assign o_pkt.packet_byte    = r_res.packet_byte;
    assign o_pkt.byte_index     = r_res.byte_index;
    assign o_pkt.is_async       = r_res.is_async;
    assign o_pkt.last_of_packet = r_res.last_of_packet;

endmodule

// ===== test/response_packet_deframer_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels, predicts the deframed packet bytes from the accepted
// rx transactions and compares them with the transactions on the packet side.
module response_packet_deframer_checker import rpd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    rpd_byte_if  i_rx,
    rpd_pkt_if   i_pkt,
    output int   o_pending,
    output int   o_mismatches
);

    // predictor state
    t_phase           frame_phase;
    logic             frame_async;
    logic [IDX_W-1:0] taken_count;
    logic [7:0]       held_byte;
    logic [IDX_W-1:0] frame_len;

    t_result packet_bytes_due[$];

    function automatic void queue_packet_byte(input logic [7:0] data_b,
                                              input logic [IDX_W-1:0] idx,
                                              input logic is_last);
        t_result r;
        r.packet_byte    = data_b;
        r.byte_index     = idx;
        r.is_async       = frame_async;
        r.last_of_packet = is_last;
        packet_bytes_due.insert(packet_bytes_due.size(), r);
    endfunction

    // one received byte through the framer; a packet byte leaves one byte late
    function automatic void deframe_byte(input logic [7:0] data_b);
        logic [IDX_W-1:0] k;
        case (frame_phase)
            PH_HUNT: begin
                frame_phase = (data_b == SOP_FIRST) ? PH_FIRST : PH_HUNT;
            end
            PH_FLUSH: begin
                queue_packet_byte(held_byte, frame_len - 17'd1, 1'b1);
                frame_phase = (data_b == SOP_FIRST) ? PH_FIRST : PH_HUNT;
            end
            PH_FIRST: begin
                if (data_b == SOP_SYNC || data_b == SOP_ASYNC) begin
                    frame_async = (data_b == SOP_ASYNC);
                    queue_packet_byte(SOP_FIRST, '0, 1'b0);
                    held_byte   = data_b;
                    taken_count = FIRST_BODY;
                    frame_len   = '0;
                    frame_phase = PH_BODY;
                end else begin
                    // broken start pair: drop the 0xFF, this byte is not a start
                    frame_phase = PH_HUNT;
                end
            end
            default: begin
                k = taken_count;
                queue_packet_byte(held_byte, k - 17'd1, 1'b0);
                if (k == LEN_BYTE_POS) begin
                    if (frame_async)
                        frame_len = HEADER_BYTES + {1'b0, held_byte, data_b};
                    else
                        frame_len = HEADER_BYTES + {9'd0, data_b};
                end
                held_byte   = data_b;
                taken_count = k + 17'd1;
                if (k >= LEN_BYTE_POS && taken_count >= frame_len)
                    frame_phase = PH_FLUSH;
            end
        endcase
    endfunction

    // predict on rx transactions, check packet transactions
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            frame_phase = PH_HUNT;
            frame_async = 1'b0;
            taken_count = '0;
            held_byte   = '0;
            frame_len   = '0;
            packet_bytes_due.delete();
        end else begin
            if (i_rx.valid && i_rx.ready)
                deframe_byte(i_rx.rx_byte);
            if (i_pkt.valid && i_pkt.ready) begin
                if (packet_bytes_due.size() == 0) begin
                    $display("%0t: unexpected packet byte %02h idx %0d async %0b last %0b",
                             $time, i_pkt.packet_byte, i_pkt.byte_index, i_pkt.is_async,
                             i_pkt.last_of_packet);
                    o_mismatches++;
                end else begin
                    want = packet_bytes_due.pop_front();
                    if (i_pkt.packet_byte !== want.packet_byte ||
                        i_pkt.byte_index !== want.byte_index ||
                        i_pkt.is_async !== want.is_async ||
                        i_pkt.last_of_packet !== want.last_of_packet) begin
                        $display("%0t: mismatch: expected byte %02h idx %0d async %0b last %0b",
                                 $time, want.packet_byte, want.byte_index, want.is_async,
                                 want.last_of_packet);
                        $display("%0t:           actual byte %02h idx %0d async %0b last %0b",
                                 $time, i_pkt.packet_byte, i_pkt.byte_index, i_pkt.is_async,
                                 i_pkt.last_of_packet);
                        o_mismatches++;
                    end
                end
            end
        end
        o_pending = packet_bytes_due.size();
    end

endmodule

// ===== test/response_packet_deframer_core_tb.sv =====
`timescale 1ns / 1ps

module response_packet_deframer_core_tb;
    import rpd_pkg::*;

    localparam int unsigned RANDOM_BYTES = 620;
    localparam int unsigned HOLD_CYCLES  = 200;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rpd_byte_if rx_if ();
    rpd_pkt_if  pkt_if ();

    int pending;
    int mismatches;

    // side controls shared by sender and receiver
    logic        steady  = 1'b0;
    logic        hold_go = 1'b0;
    int unsigned sent_count = 0;

    // directed opening: broken pairs, empty packets of both kinds,
    // back-to-back flush by a start byte, flush by a plain byte, short payloads
    logic [7:0] opening_seq [0:28] = '{
        8'hFF, 8'h01,
        8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00,
        8'hFF, 8'hFE, 8'hFF, 8'h00, 8'h00,
        8'hFF, 8'hFD,
        8'hFF, 8'hFE, 8'h5A, 8'h00, 8'h02, 8'hC3, 8'h3C,
        8'h80,
        8'hFF, 8'hFF, 8'hA5, 8'h01, 8'h01, 8'hFF,
        8'h00
    };

    response_packet_deframer_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_pkt   (pkt_if)
    );

    response_packet_deframer_checker frame_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx         (rx_if),
        .i_pkt        (pkt_if),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    always #6 i_clk = ~i_clk;

    // one rx transaction, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] data_b);
        while (!steady && $urandom_range(99) < 24) begin
            rx_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= data_b;
        do @(posedge i_clk); while (!rx_if.ready);
        sent_count++;
        @(negedge i_clk);
    endtask

    // well-formed packet with random header filler and payload
    task automatic send_frame(input logic async_kind, input logic [15:0] payload_len);
        logic [7:0]  len_hi;
        int unsigned n;
        len_hi = async_kind ? payload_len[15:8] : 8'($urandom_range(255));
        send_byte(SOP_FIRST);
        send_byte(async_kind ? SOP_ASYNC : SOP_SYNC);
        send_byte(8'($urandom_range(255)));
        send_byte(len_hi);
        send_byte(payload_len[7:0]);
        for (n = 0; n < payload_len; n++)
            send_byte(8'($urandom_range(255)));
    endtask

    // receiver: random stalls, one long hold-off, a stall-free stretch
    initial begin
        pkt_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_go) begin
                hold_go = 1'b0;
                pkt_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                pkt_if.ready <= steady || ($urandom_range(99) >= 24);
            end
        end
    end

    // stimulus and verdict
    initial begin
        int unsigned random_start;
        int unsigned done_cnt;
        int unsigned pick;
        int unsigned sel;
        int unsigned i;
        logic        kind;
        logic [15:0] len;
        logic        hold_fired;

        hold_fired    = 1'b0;
        i_rst_n       = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (i = 0; i < 29; i++)
            send_byte(opening_seq[i]);

        // random mix: mostly packets, some noise and broken start pairs
        random_start = sent_count;
        done_cnt     = 0;
        while (done_cnt < RANDOM_BYTES) begin
            if (!hold_fired && done_cnt >= 100) begin
                hold_fired = 1'b1;
                hold_go    = 1'b1;
            end
            steady = (done_cnt >= 250 && done_cnt < 420);
            pick = $urandom_range(99);
            if (pick < 70) begin
                kind = 1'($urandom_range(1));
                sel  = $urandom_range(99);
                if (sel < 85)
                    len = 16'($urandom_range(12));
                else if (sel < 97)
                    len = 16'($urandom_range(40, 13));
                else
                    len = kind ? 16'($urandom_range(300, 200)) : 16'd255;
                send_frame(kind, len);
            end else if (pick < 85) begin
                repeat ($urandom_range(4, 1))
                    send_byte(8'($urandom_range(253)));
            end else begin
                send_byte(SOP_FIRST);
                send_byte(8'($urandom_range(253)));
            end
            done_cnt = sent_count - random_start;
        end
        steady = 1'b0;

        // empty asynchronous packet, then a plain byte to flush its last byte
        send_frame(1'b1, 16'd0);
        send_byte(8'h00);

        rx_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);

        if (mismatches == 0)
            $display("PASS response_packet_deframer_core");
        else
            $display("FAIL response_packet_deframer_core");
        $finish;
    end

    // run limit
    initial begin
        #18_000_000;
        $display("FAIL response_packet_deframer_core");
        $finish;
    end

endmodule
